// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CEW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define CEW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/cew_pkg.sv =====
`default_nettype none
package cew_pkg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_ISSUE,
        ST_DRAIN,
        ST_EDGE,
        ST_DIV,
        ST_FIN
    } t_state;

    localparam int CfgW    = 11;
    localparam int CfgIdxW = 2;
    localparam int ChanW   = 8;
    localparam int PixW    = 24;
    localparam int DistW   = 18;
    localparam int BetaW   = 24;
    localparam int WgtW    = 16;
    localparam int SumW    = 40;
    localparam int GainW   = 8;

    localparam logic [CfgIdxW-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_GAIN   = 2'd2;

    localparam logic [CfgW-1:0]  WIDTH_RESET  = 11'd1024;
    localparam logic [CfgW-1:0]  HEIGHT_RESET = 11'd1024;
    localparam logic [GainW-1:0] GAIN_RESET   = 8'd50;

    localparam logic [15:0] INV_SQRT2 = 16'd46341;

    function automatic logic [DistW-1:0] dist2(logic [PixW-1:0] a, logic [PixW-1:0] b);
        logic [8:0]       df;
        logic [7:0]       mag;
        logic [15:0]      sq;
        logic [DistW-1:0] s;
        s = '0;
        for (int c = 0; c < 3; c++) begin
            df  = {1'b0, a[c*8 +: 8]} - {1'b0, b[c*8 +: 8]};
            mag = df[8] ? 8'(-df) : df[7:0];
            sq  = {8'd0, mag} * {8'd0, mag};
            s   = s + {2'b00, sq};
        end
        return s;
    endfunction

endpackage
`default_nettype wire

// ===== sv/contrast_edge_weight_engine.sv =====
// A pixel taken in ST_IDLE passes ST_LOAD, ST_ISSUE, ST_DRAIN and ST_FIN, which registers
// the result; on the last pixel of a statistics pass with a nonzero sum, ST_EDGE and ST_DIV
// run the one-bit-a-cycle divider (NUM_W = 47 at default sizes) before ST_FIN.
// Pixels are taken one at a time; four neighbors share one six-stage weight pipeline.
// Reset: synchronous, active low; afterwards every line buffer entry is zeroed
// while the pixel input is held off (configuration writes are still taken).
`default_nettype none
module contrast_edge_weight_engine #(
    parameter int MAX_WIDTH       = 1024,
    parameter int MAX_HEIGHT      = 1024,
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [cew_pkg::CfgIdxW-1:0]         i_cfg_index,
    input  logic [cew_pkg::CfgW-1:0]            i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_func,
    input  logic [cew_pkg::ChanW-1:0]           i_red,
    input  logic [cew_pkg::ChanW-1:0]           i_green,
    input  logic [cew_pkg::ChanW-1:0]           i_blue,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [cew_pkg::WgtW-1:0]            o_left_weight,
    output logic [cew_pkg::WgtW-1:0]            o_upleft_weight,
    output logic [cew_pkg::WgtW-1:0]            o_up_weight,
    output logic [cew_pkg::WgtW-1:0]            o_upright_weight,
    output logic [cew_pkg::BetaW-1:0]           o_beta_value,
    output logic                                o_frame_end
);
    import cew_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int IW  = $clog2(EXP_TABLE_DEPTH);
    localparam int EW  = $clog2(4 * MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int NW  = EW + BetaW;
    localparam int DW  = SumW + 1;
    localparam int XW  = BetaW + DistW;
    localparam int PW  = 29 + $clog2(EXP_TABLE_DEPTH + 1);
    localparam int TW  = 17;
    localparam int GW  = GainW + TW;
    localparam logic [63:0] RomStep = (64'd1 << 35) / EXP_TABLE_DEPTH;

    typedef logic [TW-1:0] t_rom [EXP_TABLE_DEPTH];

    function automatic t_rom build_rom();
        t_rom        rom;
        logic [63:0] term;
        logic [63:0] r;
        logic [63:0] e;
        term = 64'd1 << 31;
        r    = term;
        e    = term;
        for (int k = 1; k <= 16; k++) begin
            term = ((term * RomStep) >> 31) / 64'(k);
            if ((k % 2) == 1) begin
                r = r - term;
            end else begin
                r = r + term;
            end
        end
        for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
            rom[i] = TW'((e + (64'd1 << 14)) >> 15);
            e      = (e * r + (64'd1 << 30)) >> 31;
        end
        return rom;
    endfunction

    localparam t_rom ExpRom = build_rom();

    t_state r_state, n_state;

    logic [CfgW-1:0]  r_cfg_w, r_cfg_h;
    logic [GainW-1:0] r_gain;
    logic [WW-1:0]    w_eff;
    logic [HW-1:0]    h_eff;

    logic [CW-1:0]    r_clr;
    logic [PixW-1:0]  mem [MAX_WIDTH];
    logic [PixW-1:0]  r_up_q, r_ur_q;
    logic [CW-1:0]    addr_ur;

    logic [PixW-1:0]  r_cur, r_left, r_upleft;
    logic             r_stats;
    logic [CW-1:0]    r_col;
    logic [RW-1:0]    r_row;
    logic [PixW-1:0]  r_nb [4];
    logic [3:0]       r_ex;
    logic             r_fend;
    logic [1:0]       r_k;

    logic             r_v1, r_v2, r_v3, r_v4, r_v5;
    logic [1:0]       r_t1, r_t2, r_t3, r_t4, r_t5;
    logic [DistW-1:0] r_d;
    logic [XW-1:0]    r_x;
    logic [IW-1:0]    r_idx;
    logic             r_ovf3, r_ovf4, r_ovf5;
    logic [TW-1:0]    r_tv;
    logic [GW-1:0]    r_g;
    logic [WgtW-1:0]  r_w [4];

    logic [SumW-1:0]  r_sum;
    logic [BetaW-1:0] r_beta;

    logic             r_out_valid;
    logic [WgtW-1:0]  r_o_l, r_o_ul, r_o_u, r_o_ur;
    logic [BetaW-1:0] r_o_beta;
    logic             r_o_fend;

    logic             acc_in, clear_en, issue_en, div_start, load_out, pipe_busy;
    logic             row_end, frame_end_c, has_left, has_up, has_ur;
    logic [PW-1:0]    p_idx, idx_full;
    logic             ovf_c;
    logic [40:0]      diag_p;
    logic [GW:0]      str_p;
    logic [WgtW-1:0]  w_val;
    logic [SumW:0]    sum_add;
    logic [EW+1:0]    wx, hx, edges_full;
    logic             div_done;
    logic [NW-1:0]    div_quot;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= WIDTH_RESET;
            r_cfg_h <= HEIGHT_RESET;
            r_gain  <= GAIN_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_WIDTH:  r_cfg_w <= i_cfg_data;
                REG_HEIGHT: r_cfg_h <= i_cfg_data;
                REG_GAIN:   r_gain  <= i_cfg_data[GainW-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        if (r_cfg_w == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_cfg_w) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            h_eff = HW'(1);
        end else if (32'(r_cfg_h) > MAX_HEIGHT) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(r_cfg_h);
        end
    end

    assign pipe_busy = r_v1 | r_v2 | r_v3 | r_v4 | r_v5;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (r_clr == CW'(MAX_WIDTH - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (i_valid) n_state = ST_LOAD;
            ST_LOAD:  n_state = ST_ISSUE;
            ST_ISSUE: if (r_k == 2'd3) n_state = ST_DRAIN;
            ST_DRAIN: begin
                if (!pipe_busy) begin
                    if (r_fend && r_stats && (r_sum != '0)) begin
                        n_state = ST_EDGE;
                    end else begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_EDGE:  n_state = ST_DIV;
            ST_DIV:   if (div_done) n_state = ST_FIN;
            ST_FIN:   if (!r_out_valid || i_ready) n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_ready   = 1'b0;
        clear_en  = 1'b0;
        issue_en  = 1'b0;
        div_start = 1'b0;
        load_out  = 1'b0;
        case (r_state)
            ST_CLEAR: clear_en  = 1'b1;
            ST_IDLE:  o_ready   = 1'b1;
            ST_ISSUE: issue_en  = 1'b1;
            ST_EDGE:  div_start = 1'b1;
            ST_FIN:   load_out  = !r_out_valid || i_ready;
            default:  ;
        endcase
    end

    assign acc_in = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            if (clear_en) r_clr <= r_clr + 1'b1;
            if (issue_en) begin
                r_k <= r_k + 1'b1;
            end else begin
                r_k <= '0;
            end
        end
    end

    assign addr_ur = (r_col == CW'(MAX_WIDTH - 1)) ? '0 : r_col + 1'b1;

    always_ff @(posedge i_clk) begin
        if (clear_en) begin
            mem[r_clr] <= '0;
        end else if (r_state == ST_LOAD) begin
            mem[r_col] <= r_cur;
        end
        if (acc_in) begin
            r_up_q <= mem[r_col];
            r_ur_q <= mem[addr_ur];
        end
    end

    always_comb begin
        has_left    = r_col != '0;
        has_up      = r_row != '0;
        has_ur      = has_up && (32'(r_col) + 1 < 32'(w_eff));
        row_end     = 32'(r_col) + 1 >= 32'(w_eff);
        frame_end_c = row_end && (32'(r_row) + 1 >= 32'(h_eff));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_upleft <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_fend   <= 1'b0;
            r_stats  <= 1'b0;
        end else begin
            if (acc_in) begin
                r_stats <= !i_func;
            end
            if (r_state == ST_LOAD) begin
                r_left   <= r_cur;
                r_upleft <= r_up_q;
                r_fend   <= frame_end_c;
                if (row_end) begin
                    r_col <= '0;
                    r_row <= frame_end_c ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_cur <= {i_red, i_green, i_blue};
        end
        if (r_state == ST_LOAD) begin
            r_nb[0] <= r_left;
            r_nb[1] <= r_upleft;
            r_nb[2] <= r_up_q;
            r_nb[3] <= r_ur_q;
            r_ex    <= {has_ur, has_up, has_left && has_up, has_left};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= issue_en;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_comb begin
        p_idx    = PW'(r_x[27:0]) * PW'(EXP_TABLE_DEPTH) + (PW'(1) << 27);
        idx_full = p_idx >> 28;
        ovf_c    = (|r_x[XW-1:28]) || (idx_full >= PW'(EXP_TABLE_DEPTH));
        diag_p   = {16'd0, r_g} * {25'd0, INV_SQRT2} + (41'd1 << 23);
        str_p    = {1'b0, r_g} + (GW+1)'(128);
        w_val    = r_t5[0] ? diag_p[39:24] : str_p[23:8];
    end

    always_ff @(posedge i_clk) begin
        r_t1   <= r_k;
        r_d    <= dist2(r_cur, r_nb[r_k]);
        r_t2   <= r_t1;
        r_x    <= {{DistW{1'b0}}, r_beta} * {{BetaW{1'b0}}, r_d};
        r_t3   <= r_t2;
        r_idx  <= IW'(idx_full);
        r_ovf3 <= ovf_c;
        r_t4   <= r_t3;
        r_tv   <= ExpRom[r_idx];
        r_ovf4 <= r_ovf3;
        r_t5   <= r_t4;
        r_g    <= {{TW{1'b0}}, r_gain} * {{GainW{1'b0}}, r_tv};
        r_ovf5 <= r_ovf4;
        if (r_state == ST_LOAD) begin
            for (int i = 0; i < 4; i++) begin
                r_w[i] <= '0;
            end
        end else if (r_v5) begin
            r_w[r_t5] <= (r_ovf5 || !r_ex[r_t5] || r_stats) ? '0 : w_val;
        end
    end

    assign sum_add = {1'b0, r_sum} + (SumW+1)'(r_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (r_v1 && r_stats && r_ex[r_t1]) begin
            r_sum <= sum_add[SumW] ? '1 : sum_add[SumW-1:0];
        end else if (load_out && r_fend) begin
            r_sum <= '0;
        end
    end

    always_comb begin
        wx         = (EW+2)'(w_eff);
        hx         = (EW+2)'(h_eff);
        edges_full = wx * hx * (EW+2)'(4) + (EW+2)'(2) - wx * (EW+2)'(3) - hx * (EW+2)'(3);
    end

    cew_div #(
        .NUM_W (NW),
        .DEN_W (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ({edges_full[EW-1:0], {BetaW{1'b0}}}),
        .i_den   ({r_sum, 1'b0}),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beta <= '0;
        end else if (r_state == ST_DRAIN && !pipe_busy && r_fend && r_stats
                     && r_sum == '0) begin
            r_beta <= '0;
        end else if (r_state == ST_DIV && div_done) begin
            r_beta <= (|div_quot[NW-1:BetaW]) ? '1 : div_quot[BetaW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_o_beta    <= '0;
            r_o_fend    <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
            r_o_beta    <= r_beta;
            r_o_fend    <= r_fend;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_l  <= r_w[0];
            r_o_ul <= r_w[1];
            r_o_u  <= r_w[2];
            r_o_ur <= r_w[3];
        end
    end

    assign o_valid          = r_out_valid;
    assign o_left_weight    = r_o_l;
    assign o_upleft_weight  = r_o_ul;
    assign o_up_weight      = r_o_u;
    assign o_upright_weight = r_o_ur;
    assign o_beta_value     = r_o_beta;
    assign o_frame_end      = r_o_fend;

endmodule
`default_nettype wire

// ===== sv/cew_div.sv =====
`default_nettype none
module cew_div #(
    parameter int NUM_W = 51,
    parameter int DEN_W = 41
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);
    localparam int CntW = $clog2(NUM_W);

    logic             r_busy;
    logic             r_done;
    logic [CntW-1:0]  r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_sub;
    logic             q_bit;

    always_comb begin
        rem_sh  = {r_rem, r_num[NUM_W-1]};
        q_bit   = rem_sh >= {1'b0, r_den};
        rem_sub = q_bit ? (rem_sh - {1'b0, r_den}) : rem_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CntW'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_rem <= rem_sub[DEN_W-1:0];
            r_q   <= {r_q[NUM_W-2:0], q_bit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule
`default_nettype wire

// ===== sv/cew_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module cew_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_valid,
    input wire logic                      o_ready,
    input wire logic                      o_valid,
    input wire logic                      i_ready,
    input wire logic [cew_pkg::BetaW-1:0] o_beta_value,
    input wire logic                      o_frame_end
);
    `CEW_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    `CEW_ASSERT_NEXT(a_fend_hold, i_clk, i_rst_n, o_valid && !i_ready, $stable(o_frame_end))
    `CEW_ASSERT_NEXT(a_busy_after_in, i_clk, i_rst_n, i_valid && o_ready, !o_ready)
    `CEW_ASSERT_IMPL(a_beta_at_fend, i_clk, i_rst_n, !$stable(o_beta_value), o_valid && o_frame_end)
endmodule

bind contrast_edge_weight_engine cew_checker u_cew_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_beta_value (o_beta_value),
    .o_frame_end  (o_frame_end)
);
`default_nettype wire
